/* hw/rtl/nbbw_pkg.sv */
// ----------------------------------------------------------------------------
// nbbw_pkg
// Shared constants, types and arithmetic helpers of the bag-of-words scorer.
// ----------------------------------------------------------------------------
package nbbw_pkg;

    localparam int VOCAB_WORDS  = 131072;
    localparam int LOGPROB_BITS = 24;
    localparam int COUNT_BITS   = 12;

    localparam int NUM_COLUMNS  = 4;
    localparam int ADDR_W       = $clog2(VOCAB_WORDS);
    localparam int WORD_W       = 17;
    localparam int COL_W        = 2;
    localparam int RATING_W     = 4;
    localparam int ACC_W        = 48;
    localparam int CNT_W        = 24;
    localparam int PROD_W       = LOGPROB_BITS + COUNT_BITS + 1;

    // table columns
    localparam logic [COL_W-1:0] COL_POS     = 2'd0;
    localparam logic [COL_W-1:0] COL_NEG     = 2'd1;
    localparam logic [COL_W-1:0] COL_BIN_POS = 2'd2;
    localparam logic [COL_W-1:0] COL_BIN_NEG = 2'd3;

    // operation codes (s_axis_tuser)
    localparam logic OP_WRITE   = 1'b0;
    localparam logic OP_FEATURE = 1'b1;

    // configuration registers
    localparam int   CFG_IDX_W          = 1;
    localparam int   CFG_DATA_W         = 4;
    localparam logic CFG_BINARY_MODE    = 1'b0;
    localparam logic CFG_NEG_RATING_MAX = 1'b1;
    localparam logic [RATING_W-1:0] NEG_RATING_MAX_RST = 4'd4;

    // log(0.5) in Q16
    localparam logic signed [ACC_W-1:0] LOG_HALF_Q16 = -48'sd45426;
    localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

    // input tdata layout, lowest bit first
    localparam int IN_WORD_LSB   = 0;
    localparam int IN_COL_LSB    = IN_WORD_LSB + WORD_W;
    localparam int IN_VALUE_LSB  = IN_COL_LSB + COL_W;
    localparam int IN_COUNT_LSB  = IN_VALUE_LSB + LOGPROB_BITS;
    localparam int IN_RATING_LSB = IN_COUNT_LSB + COUNT_BITS;
    localparam int IN_FIELDS_W   = IN_RATING_LSB + RATING_W;
    localparam int IN_TDATA_W    = ((IN_FIELDS_W + 7) / 8) * 8;

    // output tdata layout, lowest bit first
    localparam int OUT_DEC_LSB  = 0;
    localparam int OUT_POS_LSB  = OUT_DEC_LSB + 1;
    localparam int OUT_NEG_LSB  = OUT_POS_LSB + ACC_W;
    localparam int OUT_TP_LSB   = OUT_NEG_LSB + ACC_W;
    localparam int OUT_TN_LSB   = OUT_TP_LSB + CNT_W;
    localparam int OUT_FP_LSB   = OUT_TN_LSB + CNT_W;
    localparam int OUT_FN_LSB   = OUT_FP_LSB + CNT_W;
    localparam int OUT_FIELDS_W = OUT_FN_LSB + CNT_W;
    localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

    typedef logic [LOGPROB_BITS-1:0] t_entry;

    typedef struct packed {
        logic              en;
        logic [COL_W-1:0]  col;
        logic [ADDR_W-1:0] addr;
        t_entry            data;
    } t_tbl_wr;

    function automatic logic signed [ACC_W-1:0] sat_add(
        input logic signed [ACC_W-1:0] a,
        input logic signed [ACC_W-1:0] b
    );
        logic signed [ACC_W:0] s;
        s = {a[ACC_W-1], a} + {b[ACC_W-1], b};
        if (s[ACC_W] != s[ACC_W-1]) begin
            return s[ACC_W] ? ACC_MIN : ACC_MAX;
        end
        return s[ACC_W-1:0];
    endfunction

    function automatic logic [CNT_W-1:0] cnt_inc(input logic [CNT_W-1:0] c);
        return (&c) ? c : c + 1'b1;
    endfunction

endpackage

/* hw/rtl/naive_bayes_bag_of_words_scorer.sv */
// ----------------------------------------------------------------------------
// naive_bayes_bag_of_words_scorer
// Throughput, while a full output skid does not stall the pipeline: one item
// (table write or feature) per cycle; the table banks take one write and one
// row read per cycle and the accumulators add once per cycle.
// A two-deep output register lets input continue while one result waits.
// Reset clears scores, confusion counters, configuration and pipeline; the
// table keeps its contents and is not cleared.
// ----------------------------------------------------------------------------
module naive_bayes_bag_of_words_scorer (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_we,
    input  logic [nbbw_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [nbbw_pkg::CFG_DATA_W-1:0]       i_cfg_data,
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    // word_index, column, table_value, word_count, rating
    input  logic [nbbw_pkg::IN_TDATA_W-1:0]       s_axis_tdata,
    input  logic                                  s_axis_tlast,   // last_feature
    input  logic                                  s_axis_tuser,   // operation
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    // decision, positive_score, negative_score, true_positives,
    // true_negatives, false_positives, false_negatives
    output logic [nbbw_pkg::OUT_TDATA_W-1:0]      m_axis_tdata
);

    localparam int AW = nbbw_pkg::ACC_W;
    localparam int CW = nbbw_pkg::CNT_W;

    // configuration
    logic                          r_binary_mode;
    logic [nbbw_pkg::RATING_W-1:0] r_neg_rating_max;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_binary_mode    <= 1'b0;
            r_neg_rating_max <= nbbw_pkg::NEG_RATING_MAX_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                nbbw_pkg::CFG_BINARY_MODE:    r_binary_mode    <= i_cfg_data[0];
                nbbw_pkg::CFG_NEG_RATING_MAX: r_neg_rating_max <= i_cfg_data;
            endcase
        end
    end

    // input decode
    logic                              r_skid_valid;
    logic                              w_en;
    logic                              w_accept;
    logic [nbbw_pkg::WORD_W-1:0]       w_word;
    logic [nbbw_pkg::COL_W-1:0]        w_col;
    nbbw_pkg::t_entry                  w_value;
    logic [nbbw_pkg::COUNT_BITS-1:0]   w_count;
    logic [nbbw_pkg::RATING_W-1:0]     w_rating;
    logic                              w_in_range;

    assign w_en          = !r_skid_valid;
    assign s_axis_tready = w_en;
    assign w_accept      = s_axis_tvalid && w_en;

    assign w_word   = s_axis_tdata[nbbw_pkg::IN_WORD_LSB +: nbbw_pkg::WORD_W];
    assign w_col    = s_axis_tdata[nbbw_pkg::IN_COL_LSB +: nbbw_pkg::COL_W];
    assign w_value  = s_axis_tdata[nbbw_pkg::IN_VALUE_LSB +: nbbw_pkg::LOGPROB_BITS];
    assign w_count  = s_axis_tdata[nbbw_pkg::IN_COUNT_LSB +: nbbw_pkg::COUNT_BITS];
    assign w_rating = s_axis_tdata[nbbw_pkg::IN_RATING_LSB +: nbbw_pkg::RATING_W];
    assign w_in_range = 32'(w_word) < 32'(nbbw_pkg::VOCAB_WORDS);

    nbbw_pkg::t_tbl_wr w_tbl_wr;
    logic [nbbw_pkg::NUM_COLUMNS-1:0][nbbw_pkg::LOGPROB_BITS-1:0] w_rd_data;

    always_comb begin
        w_tbl_wr.en   = w_accept && (s_axis_tuser == nbbw_pkg::OP_WRITE) && w_in_range;
        w_tbl_wr.col  = w_col;
        w_tbl_wr.addr = nbbw_pkg::ADDR_W'(w_word);
        w_tbl_wr.data = w_value;
    end

    nbbw_table u_table (
        .i_clk     (i_clk),
        .i_wr      (w_tbl_wr),
        .i_rd_en   (w_en),
        .i_rd_addr (nbbw_pkg::ADDR_W'(w_word)),
        .o_rd_data (w_rd_data)
    );

    // stage 1: table row arrives, form the terms
    logic                            r_s1_valid;
    logic                            r_s1_in_range;
    logic [nbbw_pkg::COUNT_BITS-1:0] r_s1_count;
    logic [nbbw_pkg::RATING_W-1:0]   r_s1_rating;
    logic                            r_s1_last;

    nbbw_pkg::t_entry                    w_pos_entry;
    nbbw_pkg::t_entry                    w_neg_entry;
    logic signed [nbbw_pkg::PROD_W-1:0]  w_pos_prod;
    logic signed [nbbw_pkg::PROD_W-1:0]  w_neg_prod;
    logic signed [AW-1:0]                w_pos_term;
    logic signed [AW-1:0]                w_neg_term;

    assign w_pos_entry = w_rd_data[r_binary_mode ? nbbw_pkg::COL_BIN_POS : nbbw_pkg::COL_POS];
    assign w_neg_entry = w_rd_data[r_binary_mode ? nbbw_pkg::COL_BIN_NEG : nbbw_pkg::COL_NEG];
    assign w_pos_prod  = $signed(w_pos_entry) * $signed({1'b0, r_s1_count});
    assign w_neg_prod  = $signed(w_neg_entry) * $signed({1'b0, r_s1_count});

    // product magnitude stays below 2^47, so it never needs saturating
    always_comb begin
        if (!r_s1_in_range) begin
            w_pos_term = '0;
            w_neg_term = '0;
        end else if (r_binary_mode) begin
            w_pos_term = AW'($signed(w_pos_entry));
            w_neg_term = AW'($signed(w_neg_entry));
        end else begin
            w_pos_term = AW'(w_pos_prod);
            w_neg_term = AW'(w_neg_prod);
        end
    end

    // stage 2: accumulate
    logic                          r_s2_valid;
    logic                          r_s2_last;
    logic [nbbw_pkg::RATING_W-1:0] r_s2_rating;
    logic signed [AW-1:0]          r_s2_pos;
    logic signed [AW-1:0]          r_s2_neg;
    logic signed [AW-1:0]          r_pos_acc;
    logic signed [AW-1:0]          r_neg_acc;
    logic signed [AW-1:0]          w_pos_sum;
    logic signed [AW-1:0]          w_neg_sum;

    assign w_pos_sum = nbbw_pkg::sat_add(r_pos_acc, r_s2_pos);
    assign w_neg_sum = nbbw_pkg::sat_add(r_neg_acc, r_s2_neg);

    // stage 3: add prior; stage 4: decide and count
    logic                          r_s3_valid;
    logic [nbbw_pkg::RATING_W-1:0] r_s3_rating;
    logic signed [AW-1:0]          r_s3_pos;
    logic signed [AW-1:0]          r_s3_neg;
    logic                          r_s4_valid;
    logic [nbbw_pkg::RATING_W-1:0] r_s4_rating;
    logic signed [AW-1:0]          r_s4_pos;
    logic signed [AW-1:0]          r_s4_neg;

    logic [CW-1:0] r_tp, r_tn, r_fp, r_fn;
    logic [CW-1:0] n_tp, n_tn, n_fp, n_fn;
    logic          w_neg_decision;
    logic          w_neg_label;
    logic          w_result_valid;
    logic [nbbw_pkg::OUT_TDATA_W-1:0] w_result;

    assign w_neg_decision = r_s4_pos < r_s4_neg;
    assign w_neg_label    = r_s4_rating <= r_neg_rating_max;
    assign w_result_valid = w_en && r_s4_valid;

    always_comb begin
        n_tp = r_tp;
        n_tn = r_tn;
        n_fp = r_fp;
        n_fn = r_fn;
        case ({w_neg_label, w_neg_decision})
            2'b00:   n_tp = nbbw_pkg::cnt_inc(r_tp);
            2'b11:   n_tn = nbbw_pkg::cnt_inc(r_tn);
            2'b10:   n_fp = nbbw_pkg::cnt_inc(r_fp);
            default: n_fn = nbbw_pkg::cnt_inc(r_fn);
        endcase
    end

    always_comb begin
        w_result = '0;
        w_result[nbbw_pkg::OUT_DEC_LSB]             = w_neg_decision;
        w_result[nbbw_pkg::OUT_POS_LSB +: AW]       = r_s4_pos;
        w_result[nbbw_pkg::OUT_NEG_LSB +: AW]       = r_s4_neg;
        w_result[nbbw_pkg::OUT_TP_LSB +: CW]        = n_tp;
        w_result[nbbw_pkg::OUT_TN_LSB +: CW]        = n_tn;
        w_result[nbbw_pkg::OUT_FP_LSB +: CW]        = n_fp;
        w_result[nbbw_pkg::OUT_FN_LSB +: CW]        = n_fn;
    end

    // control and state with reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
            r_s4_valid <= 1'b0;
            r_pos_acc  <= '0;
            r_neg_acc  <= '0;
            r_tp       <= '0;
            r_tn       <= '0;
            r_fp       <= '0;
            r_fn       <= '0;
        end else if (w_en) begin
            r_s1_valid <= w_accept && (s_axis_tuser == nbbw_pkg::OP_FEATURE);
            r_s2_valid <= r_s1_valid;
            r_s3_valid <= r_s2_valid && r_s2_last;
            r_s4_valid <= r_s3_valid;
            if (r_s2_valid) begin
                r_pos_acc <= r_s2_last ? '0 : w_pos_sum;
                r_neg_acc <= r_s2_last ? '0 : w_neg_sum;
            end
            if (r_s4_valid) begin
                r_tp <= n_tp;
                r_tn <= n_tn;
                r_fp <= n_fp;
                r_fn <= n_fn;
            end
        end
    end

    // payload pipeline
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s1_in_range <= w_in_range;
            r_s1_count    <= w_count;
            r_s1_rating   <= w_rating;
            r_s1_last     <= s_axis_tlast;
            r_s2_pos      <= w_pos_term;
            r_s2_neg      <= w_neg_term;
            r_s2_last     <= r_s1_last;
            r_s2_rating   <= r_s1_rating;
            r_s3_pos      <= w_pos_sum;
            r_s3_neg      <= w_neg_sum;
            r_s3_rating   <= r_s2_rating;
            r_s4_pos      <= nbbw_pkg::sat_add(r_s3_pos, nbbw_pkg::LOG_HALF_Q16);
            r_s4_neg      <= nbbw_pkg::sat_add(r_s3_neg, nbbw_pkg::LOG_HALF_Q16);
            r_s4_rating   <= r_s3_rating;
        end
    end

    // output register plus skid; a full skid stalls the pipeline
    logic                             r_out_valid;
    logic [nbbw_pkg::OUT_TDATA_W-1:0] r_out_data;
    logic [nbbw_pkg::OUT_TDATA_W-1:0] r_skid_data;
    logic                             w_pop;

    assign w_pop = r_out_valid && m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (w_pop) begin
                r_skid_valid <= 1'b0;
            end
        end else if (w_result_valid) begin
            if (r_out_valid && !w_pop) begin
                r_skid_valid <= 1'b1;
            end else begin
                r_out_valid <= 1'b1;
            end
        end else if (w_pop) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (w_pop) begin
                r_out_data <= r_skid_data;
            end
        end else if (w_result_valid) begin
            if (r_out_valid && !w_pop) begin
                r_skid_data <= w_result;
            end else begin
                r_out_data <= w_result;
            end
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

endmodule

/* hw/rtl/nbbw_table.sv */
// ----------------------------------------------------------------------------
// nbbw_table
// Log-probability table: one bank per column, one write and one row read per
// cycle, read data registered.
// ----------------------------------------------------------------------------
module nbbw_table (
    input  logic                                                i_clk,
    input  nbbw_pkg::t_tbl_wr                                   i_wr,
    input  logic                                                i_rd_en,
    input  logic [nbbw_pkg::ADDR_W-1:0]                         i_rd_addr,
    output logic [nbbw_pkg::NUM_COLUMNS-1:0][nbbw_pkg::LOGPROB_BITS-1:0] o_rd_data
);

    logic [nbbw_pkg::NUM_COLUMNS-1:0][nbbw_pkg::LOGPROB_BITS-1:0] r_rd;

    for (genvar c = 0; c < nbbw_pkg::NUM_COLUMNS; c++) begin : g_bank
        nbbw_pkg::t_entry r_mem [nbbw_pkg::VOCAB_WORDS];

        always_ff @(posedge i_clk) begin
            if (i_wr.en && (i_wr.col == nbbw_pkg::COL_W'(c))) begin
                r_mem[i_wr.addr] <= i_wr.data;
            end
            if (i_rd_en) begin
                r_rd[c] <= r_mem[i_rd_addr];
            end
        end
    end

    assign o_rd_data = r_rd;

endmodule

/* hw/rtl/nbbw_checker.sv */
// ----------------------------------------------------------------------------
// nbbw_checker
// Port-level checks of the scorer, bound to the top level.
// ----------------------------------------------------------------------------
module nbbw_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              s_axis_tvalid,
    input logic                              s_axis_tready,
    input logic                              m_axis_tvalid,
    input logic                              m_axis_tready,
    input logic [nbbw_pkg::OUT_TDATA_W-1:0]  m_axis_tdata
);

    localparam int AW = nbbw_pkg::ACC_W;
    localparam int CW = nbbw_pkg::CNT_W;

    logic signed [AW-1:0] w_pos;
    logic signed [AW-1:0] w_neg;
    logic [CW-1:0]        w_tp, w_tn, w_fp, w_fn;
    logic [CW-1:0]        r_tp, r_tn, r_fp, r_fn;

    assign w_pos = m_axis_tdata[nbbw_pkg::OUT_POS_LSB +: AW];
    assign w_neg = m_axis_tdata[nbbw_pkg::OUT_NEG_LSB +: AW];
    assign w_tp  = m_axis_tdata[nbbw_pkg::OUT_TP_LSB +: CW];
    assign w_tn  = m_axis_tdata[nbbw_pkg::OUT_TN_LSB +: CW];
    assign w_fp  = m_axis_tdata[nbbw_pkg::OUT_FP_LSB +: CW];
    assign w_fn  = m_axis_tdata[nbbw_pkg::OUT_FN_LSB +: CW];

    // counts seen in the previous output transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tp <= '0;
            r_tn <= '0;
            r_fp <= '0;
            r_fn <= '0;
        end else if (m_axis_tvalid && m_axis_tready) begin
            r_tp <= w_tp;
            r_tn <= w_tn;
            r_fp <= w_fp;
            r_fn <= w_fn;
        end
    end

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result dropped while stalled");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> m_axis_tvalid)
        else $error("input stalled with no result pending");

    a_decision: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[nbbw_pkg::OUT_DEC_LSB] == (w_pos < w_neg)))
        else $error("decision disagrees with scores");

    a_counts_grow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tready |->
            (w_tp >= r_tp) && (w_tn >= r_tn) && (w_fp >= r_fp) && (w_fn >= r_fn))
        else $error("confusion count went backwards");

endmodule

bind naive_bayes_bag_of_words_scorer nbbw_checker u_checker (.*);

/* sim/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the naive Bayes bag-of-words scorer. Loads the
// log-probability table, streams reviews in multinomial and binary mode under
// several rating thresholds, with random gaps on both stream sides and one
// long output stall. Every score transaction is checked against a local model
// of the scores and the confusion counts.
// ----------------------------------------------------------------------------
module tb_top;
    import nbbw_pkg::*;

    localparam int     CLK_HALF      = 4;
    localparam longint RUN_LIMIT     = 12_000_000;
    localparam int     SETTLE_CYCLES = 8;
    localparam int     HOLD_CYCLES   = 300;
    localparam int     LONG_REVIEW   = 150;
    localparam int unsigned CNT_SAT  = 24'hFFFFFF;

    localparam int TALLY_TP = 0;
    localparam int TALLY_TN = 1;
    localparam int TALLY_FP = 2;
    localparam int TALLY_FN = 3;

    localparam longint PRIOR_Q16 = -45426;      // log(0.5)
    localparam longint SCORE_HI  = 64'sh0000_7FFF_FFFF_FFFF;
    localparam longint SCORE_LO  = -SCORE_HI - 1;

    localparam logic [WORD_W-1:0] TOP_WORD = WORD_W'(VOCAB_WORDS - 1);
    localparam logic signed [LOGPROB_BITS-1:0] MOST_NEG = {1'b1, {(LOGPROB_BITS-1){1'b0}}};

    typedef struct {
        logic                           op;
        logic [WORD_W-1:0]              word;
        logic [COL_W-1:0]               col;
        logic signed [LOGPROB_BITS-1:0] value;
        logic [COUNT_BITS-1:0]          count;
        logic [RATING_W-1:0]            rating;
        logic                           last;
    } t_nb_item;

    typedef struct {
        logic             decision;
        logic [ACC_W-1:0] pos;
        logic [ACC_W-1:0] neg;
        logic [CNT_W-1:0] tp;
        logic [CNT_W-1:0] tn;
        logic [CNT_W-1:0] fp;
        logic [CNT_W-1:0] fn;
    } t_nb_score;

    class review_scoreboard;
        logic signed [LOGPROB_BITS-1:0] log_prob [int];
        longint      pos_sum;
        longint      neg_sum;
        int unsigned tally [4];
        logic        binary_mode;
        logic [RATING_W-1:0] neg_rating_max;
        t_nb_score   pending_scores [$];
        int          errors;
        int          n_scored;

        function new();
            pos_sum = 0;
            neg_sum = 0;
            foreach (tally[k]) tally[k] = 0;
            binary_mode = 1'b0;
            neg_rating_max = 4'd4;
            errors = 0;
            n_scored = 0;
        endfunction

        function longint clamp(longint x);
            if (x > SCORE_HI) return SCORE_HI;
            if (x < SCORE_LO) return SCORE_LO;
            return x;
        endfunction

        function longint entry(logic [WORD_W-1:0] w, logic [COL_W-1:0] c);
            int key;
            key = int'({w, c});
            return log_prob.exists(key) ? longint'(log_prob[key]) : 0;
        endfunction

        function void set_reg(logic idx, logic [CFG_DATA_W-1:0] val);
            if (idx == CFG_BINARY_MODE) begin
                binary_mode = val[0];
            end else begin
                neg_rating_max = val[RATING_W-1:0];
            end
        endfunction

        function int pending();
            return pending_scores.size();
        endfunction

        // Called once per accepted input transaction.
        function void absorb_item(t_nb_item it);
            longint    pv;
            longint    nv;
            longint    ps;
            longint    ns;
            logic      dec;
            logic      neg_label;
            logic      in_range;
            int        k;
            t_nb_score s;
            in_range = int'(it.word) < VOCAB_WORDS;
            if (it.op == OP_WRITE) begin
                if (in_range) log_prob[int'({it.word, it.col})] = it.value;
                return;
            end
            if (in_range) begin
                if (binary_mode) begin
                    pv = entry(it.word, COL_BIN_POS);
                    nv = entry(it.word, COL_BIN_NEG);
                end else begin
                    pv = clamp(entry(it.word, COL_POS) * longint'(it.count));
                    nv = clamp(entry(it.word, COL_NEG) * longint'(it.count));
                end
                pos_sum = clamp(pos_sum + pv);
                neg_sum = clamp(neg_sum + nv);
            end
            if (!it.last) return;
            ps = clamp(pos_sum + PRIOR_Q16);
            ns = clamp(neg_sum + PRIOR_Q16);
            dec = ps < ns;
            neg_label = it.rating <= neg_rating_max;
            if (!neg_label && !dec) begin
                k = TALLY_TP;
            end else if (neg_label && dec) begin
                k = TALLY_TN;
            end else if (neg_label) begin
                k = TALLY_FP;
            end else begin
                k = TALLY_FN;
            end
            if (tally[k] < CNT_SAT) tally[k]++;
            s.decision = dec;
            s.pos = ps[ACC_W-1:0];
            s.neg = ns[ACC_W-1:0];
            s.tp = CNT_W'(tally[TALLY_TP]);
            s.tn = CNT_W'(tally[TALLY_TN]);
            s.fp = CNT_W'(tally[TALLY_FP]);
            s.fn = CNT_W'(tally[TALLY_FN]);
            pending_scores = {pending_scores, s};
            pos_sum = 0;
            neg_sum = 0;
        endfunction

        task report(string msg);
            $display("mismatch: %s", msg);
            errors++;
        endtask

        task check_score(logic [OUT_TDATA_W-1:0] d);
            t_nb_score s;
            n_scored++;
            if (pending_scores.size() == 0) begin
                report($sformatf("result %0d arrived with nothing expected", n_scored));
                return;
            end
            s = pending_scores.pop_front();
            if (d[OUT_DEC_LSB] !== s.decision)
                report($sformatf("result %0d decision got %0b want %0b",
                                 n_scored, d[OUT_DEC_LSB], s.decision));
            if (d[OUT_POS_LSB +: ACC_W] !== s.pos)
                report($sformatf("result %0d positive_score got %0d want %0d", n_scored,
                                 $signed(d[OUT_POS_LSB +: ACC_W]), $signed(s.pos)));
            if (d[OUT_NEG_LSB +: ACC_W] !== s.neg)
                report($sformatf("result %0d negative_score got %0d want %0d", n_scored,
                                 $signed(d[OUT_NEG_LSB +: ACC_W]), $signed(s.neg)));
            if (d[OUT_TP_LSB +: CNT_W] !== s.tp)
                report($sformatf("result %0d true_positives got %0d want %0d",
                                 n_scored, d[OUT_TP_LSB +: CNT_W], s.tp));
            if (d[OUT_TN_LSB +: CNT_W] !== s.tn)
                report($sformatf("result %0d true_negatives got %0d want %0d",
                                 n_scored, d[OUT_TN_LSB +: CNT_W], s.tn));
            if (d[OUT_FP_LSB +: CNT_W] !== s.fp)
                report($sformatf("result %0d false_positives got %0d want %0d",
                                 n_scored, d[OUT_FP_LSB +: CNT_W], s.fp));
            if (d[OUT_FN_LSB +: CNT_W] !== s.fn)
                report($sformatf("result %0d false_negatives got %0d want %0d",
                                 n_scored, d[OUT_FN_LSB +: CNT_W], s.fn));
        endtask
    endclass

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]   i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_data = '0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    // word_index, column, table_value, word_count, rating
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
    logic                   s_axis_tlast = 1'b0;   // last_feature
    logic                   s_axis_tuser = 1'b0;   // operation
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    // decision, positive_score, negative_score, true_positives,
    // true_negatives, false_positives, false_negatives
    logic [OUT_TDATA_W-1:0] m_axis_tdata;

    review_scoreboard  sb = new();
    logic [WORD_W-1:0] vocab_pool [$];   // words with all four columns loaded
    int                n_sent = 0;
    bit                calm = 1'b0;
    bit                tx_gappy = 1'b1;
    bit                rx_hold_req = 1'b0;

    naive_bayes_bag_of_words_scorer u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        #(CLK_HALF) i_clk = 1'b1;
        #(CLK_HALF) i_clk = 1'b0;
    end

    function automatic logic signed [LOGPROB_BITS-1:0] pick_value();
        int v;
        case ($urandom_range(0, 9))
            0: return MOST_NEG;
            1: return '0;
            2: return '1;
            3, 4: v = $urandom_range(0, 8388608);
            default: v = $urandom_range(0, 1 << 18);
        endcase
        return LOGPROB_BITS'(-v);
    endfunction

    function automatic logic [COUNT_BITS-1:0] pick_count();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            2, 3: return COUNT_BITS'($urandom_range(0, 4095));
            default: return COUNT_BITS'($urandom_range(1, 16));
        endcase
    endfunction

    function automatic logic [WORD_W-1:0] pool_word();
        return vocab_pool[$urandom_range(0, vocab_pool.size() - 1)];
    endfunction

    // Holds the transaction until accepted, then maybe drops valid for a burst.
    task automatic send_item(t_nb_item it);
        logic [IN_TDATA_W-1:0] d;
        d = '0;
        d[IN_WORD_LSB +: WORD_W] = it.word;
        d[IN_COL_LSB +: COL_W] = it.col;
        d[IN_VALUE_LSB +: LOGPROB_BITS] = it.value;
        d[IN_COUNT_LSB +: COUNT_BITS] = it.count;
        d[IN_RATING_LSB +: RATING_W] = it.rating;
        s_axis_tdata <= d;
        s_axis_tuser <= it.op;
        s_axis_tlast <= it.last;
        s_axis_tvalid <= 1'b1;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        sb.absorb_item(it);
        n_sent++;
        if ($urandom_range(0, 79) == 0) tx_gappy = !tx_gappy;
        if (!calm && tx_gappy && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge i_clk);
        end
    endtask

    task automatic write_entry(logic [WORD_W-1:0] w, logic [COL_W-1:0] c,
                               logic signed [LOGPROB_BITS-1:0] v);
        t_nb_item it;
        it.op = OP_WRITE;
        it.word = w;
        it.col = c;
        it.value = v;
        it.count = COUNT_BITS'($urandom_range(0, 4095));
        it.rating = RATING_W'($urandom_range(0, 15));
        it.last = 1'($urandom_range(0, 1));
        send_item(it);
    endtask

    task automatic send_feature(logic [WORD_W-1:0] w, logic [COUNT_BITS-1:0] n,
                                logic [RATING_W-1:0] r, logic last);
        t_nb_item it;
        it.op = OP_FEATURE;
        it.word = w;
        it.col = COL_W'($urandom_range(0, 3));
        it.value = pick_value();
        it.count = n;
        it.rating = r;
        it.last = last;
        send_item(it);
    endtask

    task automatic fill_pool(int n_words);
        logic [WORD_W-1:0] w;
        repeat (n_words) begin
            w = WORD_W'($urandom);
            write_entry(w, COL_POS, pick_value());
            write_entry(w, COL_NEG, pick_value());
            write_entry(w, COL_BIN_POS, pick_value());
            write_entry(w, COL_BIN_NEG, pick_value());
            vocab_pool = {vocab_pool, w};
        end
    endtask

    // One review; now and then a table write lands just ahead of the feature
    // that reads the same word.
    task automatic send_review();
        int                len;
        logic [WORD_W-1:0] w;
        len = ($urandom_range(0, 4) == 0) ? $urandom_range(7, 24) : $urandom_range(1, 6);
        for (int j = 0; j < len; j++) begin
            w = pool_word();
            if ($urandom_range(0, 15) == 0)
                write_entry(w, COL_W'($urandom_range(0, 3)), pick_value());
            send_feature(w, pick_count(), RATING_W'($urandom_range(0, 15)), j == len - 1);
        end
    endtask

    task automatic run_random(int n_items);
        int start;
        start = n_sent;
        while (n_sent - start < n_items) begin
            if ($urandom_range(0, 7) == 0) begin
                write_entry($urandom_range(0, 1) ? pool_word() : WORD_W'($urandom),
                            COL_W'($urandom_range(0, 3)), pick_value());
            end else begin
                send_review();
            end
        end
    endtask

    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_config(logic bin, logic [RATING_W-1:0] nrm);
        i_cfg_we <= 1'b1;
        i_cfg_index <= CFG_BINARY_MODE;
        i_cfg_data <= CFG_DATA_W'(bin);
        @(posedge i_clk);
        i_cfg_index <= CFG_NEG_RATING_MAX;
        i_cfg_data <= nrm;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        sb.set_reg(CFG_BINARY_MODE, CFG_DATA_W'(bin));
        sb.set_reg(CFG_NEG_RATING_MAX, nrm);
    endtask

    // Output side: checks each transaction, then picks the next ready level.
    initial begin : rx_side
        int   stall_left;
        int   run_left;
        int   hold_left;
        logic ready_next;
        stall_left = 0;
        run_left = 0;
        hold_left = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && m_axis_tvalid && m_axis_tready) sb.check_score(m_axis_tdata);
            if (rx_hold_req) begin
                hold_left = HOLD_CYCLES;
                rx_hold_req = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                ready_next = 1'b0;
            end else if (calm) begin
                ready_next = 1'b1;
            end else begin
                if (stall_left == 0 && run_left == 0) begin
                    if ($urandom_range(0, 2) == 0) begin
                        stall_left = $urandom_range(1, 14);
                    end else begin
                        run_left = ($urandom_range(0, 9) == 0) ? 150 : $urandom_range(1, 40);
                    end
                end
                if (stall_left > 0) begin
                    stall_left--;
                    ready_next = 1'b0;
                end else begin
                    run_left--;
                    ready_next = 1'b1;
                end
            end
            m_axis_tready <= ready_next;
        end
    end

    initial begin : stimulus
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset configuration: multinomial, ratings up to 4 are negative.
        write_entry('0, COL_POS, '0);
        write_entry('0, COL_NEG, '0);
        write_entry('0, COL_BIN_POS, '0);
        write_entry('0, COL_BIN_NEG, '0);
        write_entry(TOP_WORD, COL_POS, MOST_NEG);
        write_entry(TOP_WORD, COL_NEG, '1);
        write_entry(TOP_WORD, COL_BIN_POS, MOST_NEG);
        write_entry(TOP_WORD, COL_BIN_NEG, '1);
        write_entry(WORD_W'(1), COL_POS, '1);
        write_entry(WORD_W'(1), COL_NEG, MOST_NEG);
        write_entry(WORD_W'(1), COL_BIN_POS, '1);
        write_entry(WORD_W'(1), COL_BIN_NEG, MOST_NEG);
        vocab_pool = {vocab_pool, WORD_W'(0), WORD_W'(1), TOP_WORD};

        send_feature(TOP_WORD, '1, 4'd15, 1'b1);        // largest product
        send_feature('0, '0, 4'd0, 1'b1);               // zero count, tied scores
        send_feature(TOP_WORD, 12'd1, 4'd4, 1'b0);
        send_feature('0, '1, 4'd5, 1'b1);
        send_feature(WORD_W'(1), 12'd7, 4'd4, 1'b1);
        send_feature(WORD_W'(1), '1, 4'd9, 1'b1);
        send_feature(TOP_WORD, 12'd3, 4'd0, 1'b1);
        write_entry('0, COL_POS, -24'sd5);              // rewrite, read right after
        send_feature('0, 12'd2, 4'd15, 1'b1);

        // One long review builds a deep negative sum.
        for (int j = 0; j < LONG_REVIEW; j++)
            send_feature(WORD_W'(1), '1, 4'd10, j == LONG_REVIEW - 1);

        fill_pool(30);
        run_random(250);

        settle();
        set_config(1'b1, 4'd0);
        send_feature(TOP_WORD, '0, 4'd1, 1'b1);         // binary mode ignores the count
        run_random(250);

        settle();
        set_config(1'b0, 4'd15);
        // Output stalled for a long stretch while single-feature reviews keep coming.
        rx_hold_req = 1'b1;
        repeat (40)
            send_feature(pool_word(), pick_count(), RATING_W'($urandom_range(0, 15)), 1'b1);
        run_random(250);

        settle();
        set_config(1'b1, 4'd15);
        run_random(250);

        settle();
        set_config(1'b0, RATING_W'($urandom_range(1, 14)));
        run_random(100);
        calm = 1'b1;
        run_random(100);

        settle();
        if (sb.errors == 0) begin
            $display("[naive_bayes_bag_of_words_scorer] OK");
        end else begin
            $display("[naive_bayes_bag_of_words_scorer] ERROR");
        end
        $finish;
    end

    initial begin : watchdog
        #(RUN_LIMIT);
        $display("[naive_bayes_bag_of_words_scorer] ERROR");
        $finish;
    end

endmodule
